// ----- design/slid_pkg.sv -----
// Package with shared types, constants and control structures of the sorted key list.
`default_nettype none
package slid_pkg;

    localparam int LIST_DEPTH_DEF = 16;
    localparam int KEY_W          = 31;
    localparam int COUNT_W        = 5;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_DELETE = 1'b1;

    typedef enum logic [1:0] {
        ST_INSERTED  = 2'd0,
        ST_DELETED   = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_INS,
        S_DEL,
        S_RESP
    } t_state;

    typedef struct packed {
        logic load;
        logic ins_full;
        logic ins_put;
        logic ins_shift;
        logic del_step;
        logic del_end;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic full;
        logic idx_zero;
        logic key_ge;
        logic scan_done;
        logic out_free;
    } t_dp_sts;

endpackage
`default_nettype wire

// ----- design/slid_if.sv -----
// Handshake interfaces for the request and response channels of the sorted key list.
`default_nettype none
interface slid_req_if;
    import slid_pkg::*;

    logic             valid;
    logic             ready;
    logic             req_type;
    logic [KEY_W-1:0] key_value;

    modport source (output valid, output req_type, output key_value, input ready);
    modport sink   (input valid, input req_type, input key_value, output ready);
endinterface

interface slid_rsp_if;
    import slid_pkg::*;

    logic               valid;
    logic               ready;
    logic [1:0]         op_status;
    logic [COUNT_W-1:0] entry_count;

    modport source (output valid, output op_status, output entry_count, input ready);
    modport sink   (input valid, input op_status, input entry_count, output ready);
endinterface
`default_nettype wire

// ----- design/slid_ctrl.sv -----
// Controller state machine that sequences insert and delete requests over the key store.
`default_nettype none
module slid_ctrl (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_req_valid,
    input  wire               i_req_type,
    output logic              o_req_ready,
    input  slid_pkg::t_dp_sts i_sts,
    output slid_pkg::t_dp_cmd o_cmd
);
    import slid_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_state = (i_req_type == REQ_DELETE) ? S_DEL : S_INS;
                end
            end
            S_INS: begin
                if (i_sts.full || i_sts.idx_zero || !i_sts.key_ge) begin
                    n_state = S_RESP;
                end
            end
            S_DEL: begin
                if (i_sts.scan_done) begin
                    n_state = S_RESP;
                end
            end
            S_RESP: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_req_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_req_ready = 1'b1;
                o_cmd.load  = i_req_valid;
            end
            S_INS: begin
                if (i_sts.full) begin
                    o_cmd.ins_full = 1'b1;
                end else if (i_sts.idx_zero || !i_sts.key_ge) begin
                    o_cmd.ins_put = 1'b1;
                end else begin
                    o_cmd.ins_shift = 1'b1;
                end
            end
            S_DEL: begin
                if (i_sts.scan_done) begin
                    o_cmd.del_end = 1'b1;
                end else begin
                    o_cmd.del_step = 1'b1;
                end
            end
            S_RESP: begin
                o_cmd.emit = i_sts.out_free;
            end
            default: begin
                o_cmd       = '0;
                o_req_ready = 1'b0;
            end
        endcase
    end

endmodule
`default_nettype wire

// ----- design/slid_datapath.sv -----
// Datapath with the key memory, the scan index, the entry count and the response register.
`default_nettype none
module slid_datapath #(
    parameter int LIST_DEPTH = slid_pkg::LIST_DEPTH_DEF
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  slid_pkg::t_dp_cmd           i_cmd,
    output slid_pkg::t_dp_sts           o_sts,
    input  wire                         i_req_type,
    input  wire [slid_pkg::KEY_W-1:0]   i_key_value,
    output logic                        o_rsp_valid,
    input  wire                         i_rsp_ready,
    output logic [1:0]                  o_op_status,
    output logic [slid_pkg::COUNT_W-1:0] o_entry_count
);
    import slid_pkg::*;

    localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CW = $clog2(LIST_DEPTH + 1);

    logic [KEY_W-1:0]   r_mem [LIST_DEPTH];
    logic [KEY_W-1:0]   r_rdata;
    logic [KEY_W-1:0]   r_key;
    logic               r_found;
    logic [CW-1:0]      r_cnt;
    logic [CW-1:0]      r_idx;
    t_status            r_status;
    logic               r_out_valid;
    t_status            r_out_status;
    logic [CW-1:0]      r_out_cnt;

    logic [CW-1:0]      idx_dec;
    logic [CW-1:0]      idx_dec2;
    logic [CW-1:0]      idx_inc;
    logic [CW-1:0]      cnt_dec;
    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [KEY_W-1:0]   wr_data;
    logic [CW+COUNT_W-1:0] cnt_ext;

    assign idx_dec  = r_idx - CW'(1);
    assign idx_dec2 = r_idx - CW'(2);
    assign idx_inc  = r_idx + CW'(1);
    assign cnt_dec  = r_cnt - CW'(1);

    // Insert walks backward from the tail, delete walks forward from the head.
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = '0;
        if (i_cmd.load) begin
            rd_en = (r_cnt != '0);
            if (i_req_type == REQ_DELETE) begin
                rd_addr = '0;
            end else begin
                rd_addr = cnt_dec[AW-1:0];
            end
        end else if (i_cmd.ins_shift) begin
            rd_en   = (r_idx >= CW'(2));
            rd_addr = idx_dec2[AW-1:0];
        end else if (i_cmd.del_step) begin
            rd_en   = (idx_inc < r_cnt);
            rd_addr = idx_inc[AW-1:0];
        end
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_idx[AW-1:0];
        wr_data = r_key;
        if (i_cmd.ins_put) begin
            wr_en = 1'b1;
        end else if (i_cmd.ins_shift) begin
            wr_en   = 1'b1;
            wr_data = r_rdata;
        end else if (i_cmd.del_step && r_found) begin
            wr_en   = 1'b1;
            wr_addr = idx_dec[AW-1:0];
            wr_data = r_rdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.ins_put) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (i_cmd.del_end && r_found) begin
                r_cnt <= cnt_dec;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_key   <= i_key_value;
            r_found <= 1'b0;
            r_idx   <= (i_req_type == REQ_DELETE) ? '0 : r_cnt;
        end else if (i_cmd.ins_shift) begin
            r_idx <= idx_dec;
        end else if (i_cmd.del_step) begin
            r_idx <= idx_inc;
            if (!r_found && (r_rdata == r_key)) begin
                r_found <= 1'b1;
            end
        end
        if (i_cmd.ins_full) begin
            r_status <= ST_FULL;
        end else if (i_cmd.ins_put) begin
            r_status <= ST_INSERTED;
        end else if (i_cmd.del_end) begin
            r_status <= r_found ? ST_DELETED : ST_NOT_FOUND;
        end
        if (i_cmd.emit) begin
            r_out_status <= r_status;
            r_out_cnt    <= r_cnt;
        end
    end

    always_comb begin
        o_sts.full      = (r_cnt == CW'(LIST_DEPTH));
        o_sts.idx_zero  = (r_idx == '0);
        o_sts.key_ge    = (r_rdata >= r_key);
        o_sts.scan_done = (r_idx == r_cnt);
        o_sts.out_free  = !r_out_valid || i_rsp_ready;
    end

    assign cnt_ext       = {{COUNT_W{1'b0}}, r_out_cnt};
    assign o_rsp_valid   = r_out_valid;
    assign o_op_status   = r_out_status;
    assign o_entry_count = cnt_ext[COUNT_W-1:0];

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(LIST_DEPTH))
        else $error("Entry count exceeds the list depth.");

    a_put_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.ins_put |-> (r_cnt != CW'(LIST_DEPTH)))
        else $error("Insert stored a key into a full list.");

    a_shift_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.ins_shift |-> (r_idx != '0))
        else $error("Insert shift targeted the head slot.");

    a_del_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.del_step |-> (r_idx < r_cnt))
        else $error("Delete scan ran past the stored entries.");

    a_cmd_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({i_cmd.load, i_cmd.ins_full, i_cmd.ins_put, i_cmd.ins_shift,
                  i_cmd.del_step, i_cmd.del_end, i_cmd.emit}))
        else $error("More than one datapath command is active.");

endmodule
`default_nettype wire

// ----- design/sorted_list_insert_delete.sv -----
// Top level of the bounded ascending sorted key list with insert and delete requests.
// The block holds up to LIST_DEPTH keys in ascending order in a single-port-read memory
// and handles one request at a time, visiting one stored entry per cycle. An insert
// shifts every stored key greater than or equal to the new key up one slot while
// walking back from the tail; an insert into a full list is refused with a full status.
// A delete scans the whole list and closes the gap behind the removed key as it goes.
// The next request is taken in the cycle after the response enters the output register,
// even if that response has not yet been transferred. Every request yields exactly one
// response.
`default_nettype none
module sorted_list_insert_delete #(
    parameter int LIST_DEPTH = slid_pkg::LIST_DEPTH_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    slid_req_if.sink    i_req,
    slid_rsp_if.source  o_rsp
);
    import slid_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    slid_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_req_type  (i_req.req_type),
        .o_req_ready (i_req.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    slid_datapath #(
        .LIST_DEPTH (LIST_DEPTH)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_req_type    (i_req.req_type),
        .i_key_value   (i_req.key_value),
        .o_rsp_valid   (o_rsp.valid),
        .i_rsp_ready   (o_rsp.ready),
        .o_op_status   (o_rsp.op_status),
        .o_entry_count (o_rsp.entry_count)
    );

endmodule
`default_nettype wire

// ----- bench/tb_top.sv -----
// Self-checking testbench for the sorted key list: directed table, then random request mix.
`timescale 1ns / 1ps
module tb_top;
    import slid_pkg::*;

    localparam int LIST_DEPTH = LIST_DEPTH_DEF;
    localparam int N_RANDOM   = 1500;

    typedef struct packed {
        t_status            status;
        logic [COUNT_W-1:0] count;
    } t_outcome;

    typedef struct packed {
        logic               req;
        logic [KEY_W-1:0]   key_val;
        logic               typed;
        t_status            status;
        logic [COUNT_W-1:0] count;
    } t_row;

    logic i_clk;
    logic i_rst_n;

    slid_req_if req_if ();
    slid_rsp_if rsp_if ();

    sorted_list_insert_delete #(
        .LIST_DEPTH(LIST_DEPTH)
    ) u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_if),
        .o_rsp  (rsp_if)
    );

    logic [KEY_W-1:0] list_keys [LIST_DEPTH];
    int               fill;
    int               peak_fill;
    t_outcome         pending_q[$];
    t_row             plan [0:24];

    int mismatches;
    int checked;
    int n_inserts;
    int n_deletes;
    int status_tally [4];
    int burst_left;
    int stall_mode;
    int rx_cycle;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Applies one request to the local copy of the list and returns its outcome.
    function automatic t_outcome apply_request(logic req, logic [KEY_W-1:0] key_val);
        t_outcome res;
        int       pos;
        bit       found;
        found = 1'b0;
        pos   = fill;
        if (req == REQ_INSERT) begin
            if (fill >= LIST_DEPTH) begin
                res.status = ST_FULL;
            end else begin
                for (int i = 0; i < fill; i++) begin
                    if (!found && list_keys[i] >= key_val) begin
                        pos   = i;
                        found = 1'b1;
                    end
                end
                for (int i = fill; i > pos; i--) begin
                    list_keys[i] = list_keys[i-1];
                end
                list_keys[pos] = key_val;
                fill++;
                res.status = ST_INSERTED;
            end
        end else begin
            res.status = ST_NOT_FOUND;
            for (int i = 0; i < fill; i++) begin
                if (!found && list_keys[i] == key_val) begin
                    pos   = i;
                    found = 1'b1;
                end
            end
            if (found) begin
                for (int j = pos; j + 1 < fill; j++) begin
                    list_keys[j] = list_keys[j+1];
                end
                fill--;
                res.status = ST_DELETED;
            end
        end
        if (fill > peak_fill) peak_fill = fill;
        res.count = fill[COUNT_W-1:0];
        return res;
    endfunction

    // Favors keys already held so that duplicates and successful deletes are frequent.
    function automatic logic [KEY_W-1:0] pick_key();
        logic [KEY_W-1:0] k;
        int               sel;
        sel = $urandom_range(0, 9);
        if (sel < 4 && fill > 0) begin
            k = list_keys[$urandom_range(0, fill - 1)];
        end else if (sel < 6) begin
            k = KEY_W'($urandom_range(0, 15));
        end else if (sel == 6) begin
            case ($urandom_range(0, 3))
                0:       k = '0;
                1:       k = '1;
                2:       k = {{(KEY_W-1){1'b1}}, 1'b0};
                default: k = KEY_W'(1);
            endcase
        end else begin
            k = KEY_W'($urandom());
        end
        return k;
    endfunction

    task automatic note_mismatch(input string what);
        mismatches++;
        if (mismatches <= 10) $display("MISMATCH at %0t: %s", $realtime, what);
    endtask

    // Drives one request starting at a falling edge and returns at the falling edge after
    // its transfer.
    task automatic send_request(input logic req, input logic [KEY_W-1:0] key_val,
                                input logic use_typed, input t_outcome typed_out);
        t_outcome outcome;
        int       gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
            burst_left = $urandom_range(1, 24);
            if (gap > 0) begin
                req_if.valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        req_if.valid     <= 1'b1;
        req_if.req_type  <= req;
        req_if.key_value <= key_val;
        do @(posedge i_clk); while (!req_if.ready);
        outcome = apply_request(req, key_val);
        if (use_typed) outcome = typed_out;
        pending_q.push_back(outcome);
        if (req == REQ_INSERT) n_inserts++;
        else n_deletes++;
        burst_left--;
        @(negedge i_clk);
    endtask

    always @(negedge i_clk) begin
        rx_cycle++;
        if (rx_cycle % 80 == 0) stall_mode = $urandom_range(0, 3);
        case (stall_mode)
            0:       rsp_if.ready <= 1'b1;
            1:       rsp_if.ready <= ($urandom_range(0, 1) == 1);
            2:       rsp_if.ready <= ($urandom_range(0, 3) == 0);
            default: rsp_if.ready <= ((rx_cycle % 7) < 3);
        endcase
    end

    always @(posedge i_clk) begin
        t_outcome want;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (pending_q.size() == 0) begin
                note_mismatch($sformatf("unexpected response status %0d count %0d",
                                        rsp_if.op_status, rsp_if.entry_count));
            end else begin
                want = pending_q.pop_front();
                checked++;
                status_tally[want.status]++;
                if (rsp_if.op_status !== want.status) begin
                    note_mismatch($sformatf("op_status expected %0d got %0d",
                                            want.status, rsp_if.op_status));
                end
                if (rsp_if.entry_count !== want.count) begin
                    note_mismatch($sformatf("entry_count expected %0d got %0d",
                                            want.count, rsp_if.entry_count));
                end
            end
        end
    end

    initial begin
        #5_000_000;
        $display("Timeout: %0d responses still outstanding", pending_q.size());
        $display("Some tests failed");
        $finish;
    end

    initial begin
        logic             req;
        int               insert_pct;
        logic [KEY_W-1:0] key_val;

        i_rst_n          = 1'b0;
        req_if.valid     = 1'b0;
        req_if.req_type  = REQ_INSERT;
        req_if.key_value = '0;
        rsp_if.ready     = 1'b0;
        fill             = 0;
        peak_fill        = 0;
        mismatches       = 0;
        checked          = 0;
        n_inserts        = 0;
        n_deletes        = 0;
        burst_left       = 0;
        stall_mode       = 0;
        rx_cycle         = 0;
        foreach (status_tally[i]) status_tally[i] = 0;
        foreach (list_keys[i]) list_keys[i] = '0;

        plan = '{
            '{REQ_DELETE, 31'h0000_0000, 1'b1, ST_NOT_FOUND, 5'd0},
            '{REQ_INSERT, 31'h7FFF_FFFF, 1'b1, ST_INSERTED,  5'd1},
            '{REQ_INSERT, 31'h0000_0000, 1'b1, ST_INSERTED,  5'd2},
            '{REQ_INSERT, 31'h7FFF_FFFF, 1'b1, ST_INSERTED,  5'd3},
            '{REQ_DELETE, 31'h4000_0000, 1'b1, ST_NOT_FOUND, 5'd3},
            '{REQ_DELETE, 31'h0000_0000, 1'b1, ST_DELETED,   5'd2},
            '{REQ_INSERT, 31'h2AAA_AAAA, 1'b0, ST_INSERTED,  5'd0},
            '{REQ_INSERT, 31'h5555_5555, 1'b0, ST_INSERTED,  5'd0},
            '{REQ_INSERT, 31'h0000_0005, 1'b0, ST_INSERTED,  5'd0},
            '{REQ_INSERT, 31'h0000_0005, 1'b0, ST_INSERTED,  5'd0},
            '{REQ_INSERT, 31'h0000_0001, 1'b0, ST_INSERTED,  5'd0},
            '{REQ_INSERT, 31'h7FFF_FFFE, 1'b0, ST_INSERTED,  5'd0},
            '{REQ_INSERT, 31'h4000_0000, 1'b0, ST_INSERTED,  5'd0},
            '{REQ_INSERT, 31'h3FFF_FFFF, 1'b0, ST_INSERTED,  5'd0},
            '{REQ_INSERT, 31'h0000_0064, 1'b0, ST_INSERTED,  5'd0},
            '{REQ_INSERT, 31'h0000_0064, 1'b0, ST_INSERTED,  5'd0},
            '{REQ_INSERT, 31'h0000_0007, 1'b0, ST_INSERTED,  5'd0},
            '{REQ_INSERT, 31'h1234_5678, 1'b0, ST_INSERTED,  5'd0},
            '{REQ_INSERT, 31'h6DB6_DB6D, 1'b0, ST_INSERTED,  5'd0},
            '{REQ_INSERT, 31'h0000_0002, 1'b0, ST_INSERTED,  5'd0},
            '{REQ_INSERT, 31'h0000_0003, 1'b1, ST_FULL,      5'd16},
            '{REQ_DELETE, 31'h7FFF_FFFF, 1'b1, ST_DELETED,   5'd15},
            '{REQ_DELETE, 31'h0000_0005, 1'b0, ST_INSERTED,  5'd0},
            '{REQ_DELETE, 31'h7FFF_FFFD, 1'b1, ST_NOT_FOUND, 5'd14},
            '{REQ_INSERT, 31'h0000_0000, 1'b0, ST_INSERTED,  5'd0}
        };

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (plan[i]) begin
            send_request(plan[i].req, plan[i].key_val, plan[i].typed,
                         '{plan[i].status, plan[i].count});
        end

        // Phases alternate the insert share so the list swings between empty and full.
        for (int n = 0; n < N_RANDOM; n++) begin
            case ((n / 100) % 5)
                0:       insert_pct = 85;
                1:       insert_pct = 15;
                2:       insert_pct = 95;
                3:       insert_pct = 50;
                default: insert_pct = 5;
            endcase
            req     = ($urandom_range(0, 99) < insert_pct) ? REQ_INSERT : REQ_DELETE;
            key_val = pick_key();
            send_request(req, key_val, 1'b0, '{ST_INSERTED, '0});
        end
        req_if.valid <= 1'b0;

        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        $display("Sent %0d inserts and %0d deletes; %0d responses checked, list peaked at %0d keys.",
                 n_inserts, n_deletes, checked, peak_fill);
        $display("Outcomes: %0d inserted, %0d deleted, %0d not found, %0d refused when full.",
                 status_tally[ST_INSERTED], status_tally[ST_DELETED],
                 status_tally[ST_NOT_FOUND], status_tally[ST_FULL]);
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("%0d mismatches in total", mismatches);
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
